### rtl/sorted_merge_distinct_core_assert.svh
// Assertion macros shared by the modules that check their own behaviour.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef SORTED_MERGE_DISTINCT_CORE_ASSERT_SVH
`define SORTED_MERGE_DISTINCT_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SMD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/smd_pkg.sv
package smd_pkg;

    localparam int VALUE_W = 32;

    typedef logic signed [VALUE_W-1:0] smd_value_t;

    typedef enum logic [1:0] {
        CMD_APPEND_FIRST  = 2'd0,
        CMD_APPEND_SECOND = 2'd1,
        CMD_MERGE         = 2'd2
    } smd_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_PICK,
        ST_FLUSH
    } smd_state_t;

    // Merge request from the front end to the sequencer.
    typedef struct packed {
        logic start;
        logic ovf;
    } smd_start_t;

endpackage

### rtl/smd_store.sv
module smd_store #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  smd_pkg::smd_value_t wdata,
    input  logic [AW-1:0]       raddr,
    output smd_pkg::smd_value_t rdata
);
    import smd_pkg::*;

    smd_value_t mem [DEPTH];
    smd_value_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/smd_cmp.sv
module smd_cmp (
    input  smd_pkg::smd_value_t a,
    input  smd_pkg::smd_value_t b,
    output logic                lt,
    output logic                eq
);
    import smd_pkg::*;

    assign lt = (a < b);
    assign eq = (a == b);

endmodule

### rtl/smd_merge.sv
module smd_merge #(
    parameter int CW = 6,
    parameter int AW = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  smd_pkg::smd_start_t ctl,
    input  logic [CW-1:0]       n,
    input  logic [CW-1:0]       m,
    output logic [AW-1:0]       raddr_a,
    output logic [AW-1:0]       raddr_b,
    input  smd_pkg::smd_value_t rdata_a,
    input  smd_pkg::smd_value_t rdata_b,
    output logic                busy,
    output logic                result_valid,
    input  logic                result_stall,
    output smd_pkg::smd_value_t merged_value,
    output logic                last,
    output logic                empty_res,
    output logic                overflow
);
    import smd_pkg::*;

    smd_state_t state_reg, state_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next;
    logic [CW-1:0] n_reg, n_next, m_reg, m_next;
    logic [CW-1:0] i_adv, j_adv;
    logic          ovf_reg, ovf_next;
    logic          pend_valid_reg, pend_valid_next;
    smd_value_t    pend_value_reg, pend_value_next;
    logic          pend_empty_reg, pend_empty_next;
    logic          out_valid_reg, out_valid_next;
    smd_value_t    out_value_reg, out_value_next;
    logic          out_last_reg, out_last_next;
    logic          out_empty_reg, out_empty_next;
    logic          out_ovf_reg, out_ovf_next;

    logic          a_lt_b, a_eq_b;
    logic          a_ok, b_ok;
    smd_value_t    pick;
    logic          dup;
    logic          slot_free;

    smd_cmp u_cmp (
        .a  (rdata_a),
        .b  (rdata_b),
        .lt (a_lt_b),
        .eq (a_eq_b)
    );

    assign raddr_a = i_reg[AW-1:0];
    assign raddr_b = j_reg[AW-1:0];

    // Choose the head to take this step and advance the pointers behind it.
    always_comb
    begin
        a_ok  = (i_reg < n_reg);
        b_ok  = (j_reg < m_reg);
        i_adv = i_reg;
        j_adv = j_reg;
        pick  = rdata_a;
        if (a_ok && b_ok)
        begin
            if (a_lt_b)
            begin
                i_adv = CW'(i_reg + 1'b1);
            end
            else if (a_eq_b)
            begin
                i_adv = CW'(i_reg + 1'b1);
                j_adv = CW'(j_reg + 1'b1);
            end
            else
            begin
                pick  = rdata_b;
                j_adv = CW'(j_reg + 1'b1);
            end
        end
        else if (b_ok)
        begin
            pick  = rdata_b;
            j_adv = CW'(j_reg + 1'b1);
        end
        else
        begin
            i_adv = CW'(i_reg + 1'b1);
        end
    end

    // The pending value is also the most recently kept one for duplicate checks.
    assign dup       = pend_valid_reg && (pick == pend_value_reg);
    assign slot_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        state_next      = state_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        n_next          = n_reg;
        m_next          = m_reg;
        ovf_next        = ovf_reg;
        pend_valid_next = pend_valid_reg;
        pend_value_next = pend_value_reg;
        pend_empty_next = pend_empty_reg;
        out_valid_next  = out_valid_reg && result_stall;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        out_empty_next  = out_empty_reg;
        out_ovf_next    = out_ovf_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctl.start)
                begin
                    n_next          = n;
                    m_next          = m;
                    ovf_next        = ctl.ovf;
                    i_next          = '0;
                    j_next          = '0;
                    pend_valid_next = 1'b0;
                    pend_empty_next = 1'b0;
                    if ((n == '0) && (m == '0))
                    begin
                        pend_valid_next = 1'b1;
                        pend_value_next = '0;
                        pend_empty_next = 1'b1;
                        state_next      = ST_FLUSH;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_PICK;
            end
            ST_PICK:
            begin
                // Hold while a distinct value must push the pending one out
                // and the output register is still occupied.
                if (dup || !pend_valid_reg || slot_free)
                begin
                    i_next = i_adv;
                    j_next = j_adv;
                    if (!dup)
                    begin
                        pend_valid_next = 1'b1;
                        pend_value_next = pick;
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_value_next = pend_value_reg;
                            out_last_next  = 1'b0;
                            out_empty_next = 1'b0;
                            out_ovf_next   = ovf_reg;
                        end
                    end
                    if ((i_adv < n_reg) || (j_adv < m_reg))
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = pend_value_reg;
                    out_last_next   = 1'b1;
                    out_empty_next  = pend_empty_reg;
                    out_ovf_next    = ovf_reg;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg          <= i_next;
        j_reg          <= j_next;
        n_reg          <= n_next;
        m_reg          <= m_next;
        ovf_reg        <= ovf_next;
        pend_value_reg <= pend_value_next;
        pend_empty_reg <= pend_empty_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
        out_empty_reg  <= out_empty_next;
        out_ovf_reg    <= out_ovf_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;
    assign merged_value = out_value_reg;
    assign last         = out_last_reg;
    assign empty_res    = out_empty_reg;
    assign overflow     = out_ovf_reg;

endmodule

### rtl/sorted_merge_distinct_core.sv
// Append transactions produce no result. A merge of n and m entries runs a read
// state and then a compare state per step, because of the single shared compare
// unit and the registered list reads; the block stalls new transactions until the
// last result is loaded.
// Reset clears both counts, the dropped flag, the sequencer and the output valid
// flag; list contents are not cleared and need no clearing pass.
module sorted_merge_distinct_core #(
    parameter int MAX_LEN = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic [1:0]          command,
    input  smd_pkg::smd_value_t value,
    output logic                result_valid,
    input  logic                result_stall,
    output smd_pkg::smd_value_t merged_value,
    output logic                last,
    output logic                empty_res,
    output logic                overflow
);
    import smd_pkg::*;

    `include "sorted_merge_distinct_core_assert.svh"

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    logic [CW-1:0] first_count_reg, first_count_next;
    logic [CW-1:0] second_count_reg, second_count_next;
    logic          dropped_reg, dropped_next;
    logic          accept;
    logic          first_room, second_room;
    logic          we_first, we_second;
    logic          busy;
    smd_start_t    start;
    logic [AW-1:0] raddr_a, raddr_b;
    smd_value_t    rdata_a, rdata_b;

    assign accept      = item_valid && !item_stall;
    assign item_stall  = busy;
    assign first_room  = (first_count_reg < CW'(MAX_LEN));
    assign second_room = (second_count_reg < CW'(MAX_LEN));

    always_comb
    begin
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        dropped_next      = dropped_reg;
        we_first          = 1'b0;
        we_second         = 1'b0;
        start             = '0;
        if (accept)
        begin
            unique case (command)
                CMD_APPEND_FIRST:
                begin
                    if (first_room)
                    begin
                        we_first         = 1'b1;
                        first_count_next = CW'(first_count_reg + 1'b1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                end
                CMD_APPEND_SECOND:
                begin
                    if (second_room)
                    begin
                        we_second         = 1'b1;
                        second_count_next = CW'(second_count_reg + 1'b1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                end
                CMD_MERGE:
                begin
                    // Counts are latched by the sequencer, so clear them now.
                    start.start       = 1'b1;
                    start.ovf         = dropped_reg;
                    first_count_next  = '0;
                    second_count_next = '0;
                    dropped_next      = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_count_reg  <= '0;
            second_count_reg <= '0;
            dropped_reg      <= 1'b0;
        end
        else
        begin
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            dropped_reg      <= dropped_next;
        end
    end

    smd_store #(
        .DEPTH (MAX_LEN),
        .AW    (AW)
    ) u_first (
        .clk   (clk),
        .we    (we_first),
        .waddr (first_count_reg[AW-1:0]),
        .wdata (value),
        .raddr (raddr_a),
        .rdata (rdata_a)
    );

    smd_store #(
        .DEPTH (MAX_LEN),
        .AW    (AW)
    ) u_second (
        .clk   (clk),
        .we    (we_second),
        .waddr (second_count_reg[AW-1:0]),
        .wdata (value),
        .raddr (raddr_b),
        .rdata (rdata_b)
    );

    smd_merge #(
        .CW (CW),
        .AW (AW)
    ) u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (start),
        .n            (first_count_reg),
        .m            (second_count_reg),
        .raddr_a      (raddr_a),
        .raddr_b      (raddr_b),
        .rdata_a      (rdata_a),
        .rdata_b      (rdata_b),
        .busy         (busy),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .merged_value (merged_value),
        .last         (last),
        .empty_res    (empty_res),
        .overflow     (overflow)
    );

    `SMD_ASSERT_SAME(a_empty_is_last, result_valid && empty_res, last)
    `SMD_ASSERT_NEXT(a_merge_holds_input, accept && (command == CMD_MERGE), item_stall)
    `SMD_ASSERT_SAME(a_count_cap, 1'b1, (first_count_reg <= CW'(MAX_LEN)) && (second_count_reg <= CW'(MAX_LEN)))

endmodule

### dv/sorted_union_checker.sv
`timescale 1ns / 1ps

module sorted_union_checker #(
    parameter int LIST_DEPTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_stall,
    input  logic [1:0]          command,
    input  smd_pkg::smd_value_t value,
    input  logic                result_valid,
    input  logic                result_stall,
    input  smd_pkg::smd_value_t merged_value,
    input  logic                last,
    input  logic                empty_res,
    input  logic                overflow,
    output int                  mismatches,
    output int                  outstanding
);
    import smd_pkg::*;

    typedef struct packed {
        smd_value_t val;
        logic       last;
        logic       empty;
        logic       ovf;
    } union_entry_t;

    smd_value_t   first_store [LIST_DEPTH];
    smd_value_t   second_store[LIST_DEPTH];
    int           first_len;
    int           second_len;
    logic         dropped;
    union_entry_t expected_union[$];

    // Walk both lists, smaller head first, and drop values equal to the one just taken.
    task automatic predict_union();
        int           i;
        int           j;
        smd_value_t   pick;
        logic         have_prev;
        union_entry_t held;
        i = 0;
        j = 0;
        have_prev = 1'b0;
        held = '0;
        if (first_len == 0 && second_len == 0)
        begin
            expected_union.push_back('{val: '0, last: 1'b1, empty: 1'b1, ovf: dropped});
        end
        else
        begin
            while (i < first_len || j < second_len)
            begin
                if (i < first_len && j < second_len)
                begin
                    if (first_store[i] < second_store[j])
                    begin
                        pick = first_store[i];
                        i++;
                    end
                    else if (second_store[j] < first_store[i])
                    begin
                        pick = second_store[j];
                        j++;
                    end
                    else
                    begin
                        pick = first_store[i];
                        i++;
                        j++;
                    end
                end
                else if (j < second_len)
                begin
                    pick = second_store[j];
                    j++;
                end
                else
                begin
                    pick = first_store[i];
                    i++;
                end
                if (!have_prev || pick != held.val)
                begin
                    // hold each value back until we know whether it is the final one
                    if (have_prev)
                        expected_union.push_back(held);
                    held = '{val: pick, last: 1'b0, empty: 1'b0, ovf: dropped};
                    have_prev = 1'b1;
                end
            end
            held.last = 1'b1;
            expected_union.push_back(held);
        end
        first_len = 0;
        second_len = 0;
        dropped = 1'b0;
    endtask

    task automatic accept_item(input logic [1:0] cmd, input smd_value_t v);
        case (cmd)
            CMD_APPEND_FIRST:
            begin
                if (first_len < LIST_DEPTH)
                begin
                    first_store[first_len] = v;
                    first_len++;
                end
                else
                    dropped = 1'b1;
            end
            CMD_APPEND_SECOND:
            begin
                if (second_len < LIST_DEPTH)
                begin
                    second_store[second_len] = v;
                    second_len++;
                end
                else
                    dropped = 1'b1;
            end
            CMD_MERGE:
                predict_union();
            default:
            begin
                // unused code: no effect
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        union_entry_t want;
        logic         bad;
        if (!rst_n)
        begin
            first_len = 0;
            second_len = 0;
            dropped = 1'b0;
            mismatches = 0;
            expected_union.delete();
            outstanding <= 0;
        end
        else
        begin
            if (item_valid && !item_stall)
                accept_item(command, value);
            if (result_valid && !result_stall)
            begin
                if (expected_union.size() == 0)
                begin
                    $display("%0t: unexpected result transaction, merged_value %0d last %b",
                             $time, merged_value, last);
                    mismatches++;
                end
                else
                begin
                    want = expected_union.pop_front();
                    bad = 1'b0;
                    if (merged_value !== want.val)
                    begin
                        $display("%0t: merged_value expected %0d got %0d",
                                 $time, want.val, merged_value);
                        bad = 1'b1;
                    end
                    if (last !== want.last)
                    begin
                        $display("%0t: last expected %b got %b", $time, want.last, last);
                        bad = 1'b1;
                    end
                    if (empty_res !== want.empty)
                    begin
                        $display("%0t: empty_res expected %b got %b",
                                 $time, want.empty, empty_res);
                        bad = 1'b1;
                    end
                    if (overflow !== want.ovf)
                    begin
                        $display("%0t: overflow expected %b got %b", $time, want.ovf, overflow);
                        bad = 1'b1;
                    end
                    if (bad)
                        mismatches++;
                end
            end
            outstanding <= expected_union.size();
        end
    end

endmodule

### dv/tb_sorted_merge_distinct_core.sv
`timescale 1ns / 1ps

module tb_sorted_merge_distinct_core;
    import smd_pkg::*;

    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam int         CYCLE_LIMIT    = 250000;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         TARGET_ITEMS   = 460;
    localparam int         SHAPE_NARROW   = 0;
    localparam int         SHAPE_WIDE     = 1;
    localparam int         SHAPE_SCRAMBLE = 2;

    logic       clk;
    logic       rst_n;
    logic       item_valid;
    logic       item_stall;
    logic [1:0] command;
    smd_value_t value;
    logic       result_valid;
    logic       result_stall;
    smd_value_t merged_value;
    logic       last;
    logic       empty_res;
    logic       overflow;

    int   mismatches;
    int   outstanding;
    int   appends_and_merges;
    int   cycles;
    int   hold_left;
    logic idle_enable;
    logic hold_armed;
    logic hold_done;

    sorted_merge_distinct_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .command      (command),
        .value        (value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .merged_value (merged_value),
        .last         (last),
        .empty_res    (empty_res),
        .overflow     (overflow)
    );

    sorted_union_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .command      (command),
        .value        (value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .merged_value (merged_value),
        .last         (last),
        .empty_res    (empty_res),
        .overflow     (overflow),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off once armed.
    initial
    begin
        result_stall = 1'b0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_armed && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                while (hold_left > 0)
                begin
                    result_stall <= 1'b1;
                    @(negedge clk);
                    hold_left--;
                end
                hold_done = 1'b1;
            end
            result_stall <= idle_enable && ($urandom_range(99) < 14);
        end
    end

    // Offer one transaction and hold it until accepted.
    task automatic send_item(input logic [1:0] cmd, input smd_value_t v);
        @(negedge clk);
        if (idle_enable && $urandom_range(99) < 14)
        begin
            item_valid <= 1'b0;
            command <= 2'($urandom_range(3));
            value <= $urandom;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        command <= cmd;
        value <= v;
        do
            @(posedge clk);
        while (item_stall);
        if (cmd != CMD_UNUSED)
            appends_and_merges++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        item_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    function automatic smd_value_t next_list_value(input int shape, input smd_value_t prev,
                                                   input logic fresh);
        longint nxt;
        case (shape)
            SHAPE_NARROW:
                nxt = fresh ? longint'($urandom_range(12)) - 6
                            : longint'(prev) + longint'($urandom_range(2));
            SHAPE_WIDE:
            begin
                if (fresh)
                    nxt = ($urandom_range(5) == 0) ? longint'(32'sh80000000)
                                                   : longint'(smd_value_t'($urandom));
                else
                    nxt = longint'(prev) + longint'($urandom_range(1 << 20));
            end
            default:
                nxt = $urandom_range(1) ? longint'(smd_value_t'($urandom))
                                        : longint'($urandom_range(8)) - 4;
        endcase
        if (nxt > longint'(32'sh7FFFFFFF))
            nxt = longint'(32'sh7FFFFFFF);
        return smd_value_t'(nxt);
    endfunction

    // Load both lists in a random interleave, with an occasional unused code, then merge.
    task automatic run_merge_set(input int n_first, input int n_second, input int shape);
        int         fi;
        int         si;
        smd_value_t first_run;
        smd_value_t second_run;
        fi = 0;
        si = 0;
        first_run = '0;
        second_run = '0;
        while (fi < n_first || si < n_second)
        begin
            if (si >= n_second || (fi < n_first && $urandom_range(1) == 0))
            begin
                first_run = next_list_value(shape, first_run, fi == 0);
                send_item(CMD_APPEND_FIRST, first_run);
                fi++;
            end
            else
            begin
                second_run = next_list_value(shape, second_run, si == 0);
                send_item(CMD_APPEND_SECOND, second_run);
                si++;
            end
            if ($urandom_range(39) == 0)
                send_item(CMD_UNUSED, $urandom);
        end
        send_item(CMD_MERGE, $urandom);
    endtask

    function automatic int pick_length();
        if ($urandom_range(9) == 0)
            return 28 + $urandom_range(6);
        return $urandom_range(8);
    endfunction

    initial
    begin : stimulus
        int set_no;
        int shape_pick;
        rst_n = 1'b0;
        item_valid = 1'b0;
        command = CMD_APPEND_FIRST;
        value = '0;
        idle_enable = 1'b1;
        hold_armed = 1'b0;
        appends_and_merges = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // merge with nothing loaded
        send_item(CMD_MERGE, 32'sh7FFFFFFF);
        // extremes, equal heads on both lists, an unused code in between
        send_item(CMD_APPEND_FIRST, 32'sh80000000);
        send_item(CMD_APPEND_FIRST, -32'sd1);
        send_item(CMD_APPEND_FIRST, 32'sd0);
        send_item(CMD_APPEND_FIRST, 32'sh7FFFFFFF);
        send_item(CMD_APPEND_SECOND, 32'sh80000000);
        send_item(CMD_APPEND_SECOND, 32'sd5);
        send_item(CMD_UNUSED, $urandom);
        send_item(CMD_APPEND_SECOND, 32'sh7FFFFFFF);
        send_item(CMD_MERGE, '0);
        // unsorted input: only neighbouring repeats are removed
        send_item(CMD_APPEND_FIRST, 32'sd5);
        send_item(CMD_APPEND_FIRST, 32'sd5);
        send_item(CMD_APPEND_FIRST, 32'sd3);
        send_item(CMD_APPEND_SECOND, 32'sd3);
        send_item(CMD_MERGE, '1);
        // one list only, each side, then one equal value on both lists
        send_item(CMD_APPEND_SECOND, 32'sd9);
        send_item(CMD_APPEND_SECOND, 32'sd9);
        send_item(CMD_MERGE, '0);
        send_item(CMD_APPEND_FIRST, -32'sd4);
        send_item(CMD_MERGE, '0);
        send_item(CMD_APPEND_SECOND, -32'sd7);
        send_item(CMD_APPEND_FIRST, -32'sd7);
        send_item(CMD_MERGE, '0);
        wait_drained();

        // long hold-off on the result side while transactions keep coming
        hold_armed = 1'b1;
        run_merge_set(6, 6, SHAPE_NARROW);
        run_merge_set(5, 7, SHAPE_WIDE);
        run_merge_set(3, 2, SHAPE_SCRAMBLE);
        wait_drained();

        // both lists past capacity
        run_merge_set(34, 33, SHAPE_WIDE);

        set_no = 0;
        while (appends_and_merges < TARGET_ITEMS)
        begin
            idle_enable = !(set_no >= 8 && set_no < 15);
            shape_pick = $urandom_range(7);
            if (shape_pick == 0)
                run_merge_set(pick_length(), pick_length(), SHAPE_SCRAMBLE);
            else if (shape_pick < 4)
                run_merge_set(pick_length(), pick_length(), SHAPE_WIDE);
            else
                run_merge_set(pick_length(), pick_length(), SHAPE_NARROW);
            if ($urandom_range(9) == 0)
                wait_drained();
            set_no++;
        end
        idle_enable = 1'b1;
        wait_drained();
        repeat (40) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
